@@ sv/prrs_pkg.sv @@
// Shared types and codes of the priority round-robin semaphore.
`timescale 1ns / 1ps

package prrs_pkg;

    // Port field types (fixed by the interface)
    typedef logic [1:0]  action_t;
    typedef logic [15:0] id_port_t;
    typedef logic [1:0]  lvl_port_t;
    typedef logic [2:0]  pos_port_t;
    typedef logic [2:0]  outcome_t;
    typedef logic [15:0] tok_port_t;
    typedef logic [5:0]  waiter_t;
    typedef logic [1:0]  mark_t;

    // Action codes
    localparam action_t ACT_SET = 2'd0;
    localparam action_t ACT_ACQ = 2'd1;
    localparam action_t ACT_REL = 2'd2;

    // Outcome codes
    localparam outcome_t OC_REGISTERED = 3'd0;
    localparam outcome_t OC_ACQUIRED   = 3'd1;
    localparam outcome_t OC_BLOCKED    = 3'd2;
    localparam outcome_t OC_HANDED     = 3'd3;
    localparam outcome_t OC_TOKEN      = 3'd4;
    localparam outcome_t OC_NO_SLOT    = 3'd5;

    // Slot marks
    localparam mark_t MARK_FREE = 2'd0;
    localparam mark_t MARK_SET  = 2'd1;
    localparam mark_t MARK_WAIT = 2'd2;

    localparam waiter_t WAITER_MAX = 6'd63;

endpackage

@@ sv/prrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module prrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ sv/priority_round_robin_semaphore.sv @@
// Top level of the priority counting semaphore with round-robin wakeup.
`timescale 1ns / 1ps

// Priority counting semaphore. A word is taken when start is high and busy
// is low. Its single result appears for exactly one cycle with done high, in
// the first cycle that busy is low again. The receiver cannot hold it off.
// Set level and acquire walk the owner RAM one slot per cycle to find the
// requester (level 0 upward, slot 0 upward), stopping at its slot, or
// walk every slot when it is unknown. Release walks the levels from the
// top, one level per cycle, then, if it found a waiter, reads the woken
// owner from RAM. An unused action code answers "no free slot" without
// going busy, with done high in the cycle after start. The owner RAM's
// single read port is why the walk takes one slot at a time. No clearing
// pass: slot marks reset at once. Writing cfg_wdata with cfg_we loads the
// token counter; the user must do so only while idle, since the block
// itself does not enforce it. Outputs tokens_left and waiters_now report
// the counters after the word.
module priority_round_robin_semaphore #(
    parameter int NUM_LEVELS      = 4,
    parameter int SLOTS_PER_LEVEL = 8,
    parameter int ID_WIDTH        = 16,
    parameter int TOKEN_WIDTH     = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  prrs_pkg::action_t    action,
    input  prrs_pkg::id_port_t   requester_id,
    input  prrs_pkg::lvl_port_t  req_level,
    // result channel
    output logic                 done,
    output prrs_pkg::outcome_t   outcome,
    output prrs_pkg::lvl_port_t  slot_level,
    output prrs_pkg::pos_port_t  slot_index,
    output prrs_pkg::id_port_t   woken_id,
    output prrs_pkg::tok_port_t  tokens_left,
    output prrs_pkg::waiter_t    waiters_now,
    // configuration: initial token count
    input  logic                 cfg_we,
    input  prrs_pkg::tok_port_t  cfg_wdata
);

    localparam int NSLOTS = NUM_LEVELS * SLOTS_PER_LEVEL;
    localparam int LVL_W  = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS) : 1;
    localparam int POS_W  = SLOTS_PER_LEVEL > 1 ? $clog2(SLOTS_PER_LEVEL) : 1;
    localparam int ADDR_W = NSLOTS > 1 ? $clog2(NSLOTS) : 1;

    typedef logic [LVL_W-1:0]       lvl_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [ID_WIDTH-1:0]    id_t;
    typedef logic [TOKEN_WIDTH-1:0] tok_t;

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_DECIDE  = 3'd2;
    localparam logic [2:0] ST_REL     = 3'd3;
    localparam logic [2:0] ST_REL_OUT = 3'd4;

    function automatic addr_t slot_addr(lvl_t l, pos_t p);
        return addr_t'(int'(l) * SLOTS_PER_LEVEL + int'(p));
    endfunction

    // control state
    logic [2:0]        state_reg, state_next;
    prrs_pkg::mark_t   mark_reg [NUM_LEVELS][SLOTS_PER_LEVEL];
    prrs_pkg::mark_t   mark_next [NUM_LEVELS][SLOTS_PER_LEVEL];
    pos_t              rr_ptr_reg [NUM_LEVELS];
    pos_t              rr_ptr_next [NUM_LEVELS];
    tok_t              token_reg, token_next;
    prrs_pkg::waiter_t waiters_reg, waiters_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              done_reg, done_next;

    // per-word working registers
    prrs_pkg::action_t action_reg, action_next;
    id_t               id_reg, id_next;
    lvl_t              lvl_reg, lvl_next;
    lvl_t              scan_lvl_reg, scan_lvl_next;
    pos_t              scan_pos_reg, scan_pos_next;
    lvl_t              cmp_lvl_reg, cmp_lvl_next;
    pos_t              cmp_pos_reg, cmp_pos_next;
    logic              cmp_last_reg, cmp_last_next;
    logic              found_reg, found_next;
    lvl_t              f_lvl_reg, f_lvl_next;
    pos_t              f_pos_reg, f_pos_next;
    lvl_t              rel_lvl_reg, rel_lvl_next;

    // result registers
    prrs_pkg::outcome_t  outcome_reg, outcome_next;
    prrs_pkg::lvl_port_t slot_level_reg, slot_level_next;
    prrs_pkg::pos_port_t slot_index_reg, slot_index_next;
    prrs_pkg::id_port_t  woken_id_reg, woken_id_next;
    prrs_pkg::tok_port_t tokens_left_reg, tokens_left_next;
    prrs_pkg::waiter_t   waiters_now_reg, waiters_now_next;

    // owner RAM
    logic  ram_we;
    addr_t ram_waddr;
    addr_t ram_raddr;
    id_t   ram_rdata;

    // finders
    lvl_t  free_lvl;
    logic  free_hit;
    pos_t  free_pos;
    logic  rel_hit;
    pos_t  rel_pos;
    lvl_t  in_lvl;

    // emitted result
    prrs_pkg::outcome_t em_oc;
    lvl_t               em_lvl;
    pos_t               em_pos;
    id_t                em_woken;
    logic               go_on;
    lvl_t               tgt_lvl;
    pos_t               tgt_pos;
    prrs_pkg::mark_t    found_mark;

    prrs_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (NSLOTS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (id_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // out-of-range levels fold onto the top level
    always_comb
    begin
        if (int'(req_level) >= NUM_LEVELS)
            in_lvl = lvl_t'(NUM_LEVELS - 1);
        else
            in_lvl = lvl_t'(req_level);
    end

    // first free slot in the row used by set level (its level) or acquire (level 0)
    assign free_lvl = (action_reg == prrs_pkg::ACT_SET) ? lvl_reg : '0;

    always_comb
    begin
        free_hit = 1'b0;
        free_pos = '0;
        for (int j = SLOTS_PER_LEVEL - 1; j >= 0; j--)
        begin
            if (mark_reg[free_lvl][j] == prrs_pkg::MARK_FREE)
            begin
                free_hit = 1'b1;
                free_pos = pos_t'(j);
            end
        end
    end

    // first waiting slot of the current level, starting at its round-robin pointer
    always_comb
    begin
        int sum;
        rel_hit = 1'b0;
        rel_pos = '0;
        for (int j = SLOTS_PER_LEVEL - 1; j >= 0; j--)
        begin
            sum = int'(rr_ptr_reg[rel_lvl_reg]) + j;
            if (sum >= SLOTS_PER_LEVEL)
                sum = sum - SLOTS_PER_LEVEL;
            if (mark_reg[rel_lvl_reg][pos_t'(sum)] == prrs_pkg::MARK_WAIT)
            begin
                rel_hit = 1'b1;
                rel_pos = pos_t'(sum);
            end
        end
    end

    assign found_mark = mark_reg[f_lvl_reg][f_pos_reg];

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        mark_next        = mark_reg;
        rr_ptr_next      = rr_ptr_reg;
        token_next       = token_reg;
        waiters_next     = waiters_reg;
        cmp_vld_next     = cmp_vld_reg;
        done_next        = 1'b0;
        action_next      = action_reg;
        id_next          = id_reg;
        lvl_next         = lvl_reg;
        scan_lvl_next    = scan_lvl_reg;
        scan_pos_next    = scan_pos_reg;
        cmp_lvl_next     = cmp_lvl_reg;
        cmp_pos_next     = cmp_pos_reg;
        cmp_last_next    = cmp_last_reg;
        found_next       = found_reg;
        f_lvl_next       = f_lvl_reg;
        f_pos_next       = f_pos_reg;
        rel_lvl_next     = rel_lvl_reg;
        outcome_next     = outcome_reg;
        slot_level_next  = slot_level_reg;
        slot_index_next  = slot_index_reg;
        woken_id_next    = woken_id_reg;
        tokens_left_next = tokens_left_reg;
        waiters_now_next = waiters_now_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_addr(free_lvl, free_pos);
        ram_raddr        = slot_addr(scan_lvl_reg, scan_pos_reg);
        em_oc            = prrs_pkg::OC_NO_SLOT;
        em_lvl           = '0;
        em_pos           = '0;
        em_woken         = '0;
        go_on            = 1'b0;
        tgt_lvl          = f_lvl_reg;
        tgt_pos          = f_pos_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    action_next   = action;
                    id_next       = id_t'(requester_id);
                    lvl_next      = in_lvl;
                    scan_lvl_next = '0;
                    scan_pos_next = '0;
                    cmp_vld_next  = 1'b0;
                    cmp_last_next = 1'b0;
                    if (action == prrs_pkg::ACT_REL)
                    begin
                        rel_lvl_next = lvl_t'(NUM_LEVELS - 1);
                        state_next   = ST_REL;
                    end
                    else if (action == prrs_pkg::ACT_SET || action == prrs_pkg::ACT_ACQ)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // unused code: report no slot, change nothing
                        done_next = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                // compare the slot read last cycle, issue the next read
                if (cmp_vld_reg && mark_reg[cmp_lvl_reg][cmp_pos_reg] != prrs_pkg::MARK_FREE
                    && ram_rdata == id_reg)
                begin
                    found_next = 1'b1;
                    f_lvl_next = cmp_lvl_reg;
                    f_pos_next = cmp_pos_reg;
                    state_next = ST_DECIDE;
                end
                else if (cmp_vld_reg && cmp_last_reg)
                begin
                    found_next = 1'b0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_lvl_next  = scan_lvl_reg;
                    cmp_pos_next  = scan_pos_reg;
                    cmp_last_next = (int'(scan_lvl_reg) == NUM_LEVELS - 1)
                                    && (int'(scan_pos_reg) == SLOTS_PER_LEVEL - 1);
                    if (int'(scan_pos_reg) == SLOTS_PER_LEVEL - 1)
                    begin
                        scan_pos_next = '0;
                        scan_lvl_next = lvl_t'(int'(scan_lvl_reg) + 1);
                    end
                    else
                    begin
                        scan_pos_next = pos_t'(int'(scan_pos_reg) + 1);
                    end
                end
            end

            ST_DECIDE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (action_reg == prrs_pkg::ACT_SET)
                begin
                    if (found_reg && f_lvl_reg == lvl_reg)
                    begin
                        em_oc  = prrs_pkg::OC_REGISTERED;
                        em_lvl = f_lvl_reg;
                        em_pos = f_pos_reg;
                    end
                    else if (!free_hit)
                    begin
                        // target level full: old slot untouched
                        em_oc  = prrs_pkg::OC_NO_SLOT;
                        em_lvl = lvl_reg;
                    end
                    else
                    begin
                        mark_next[lvl_reg][free_pos] = found_reg ? found_mark
                                                                 : prrs_pkg::MARK_SET;
                        if (found_reg)
                            mark_next[f_lvl_reg][f_pos_reg] = prrs_pkg::MARK_FREE;
                        ram_we = 1'b1;
                        em_oc  = prrs_pkg::OC_REGISTERED;
                        em_lvl = lvl_reg;
                        em_pos = free_pos;
                    end
                end
                else
                begin
                    go_on = 1'b1;
                    if (!found_reg)
                    begin
                        if (!free_hit)
                        begin
                            em_oc = prrs_pkg::OC_NO_SLOT;
                            go_on = 1'b0;
                        end
                        else
                        begin
                            // register at level 0 on the fly
                            tgt_lvl = '0;
                            tgt_pos = free_pos;
                            mark_next[0][free_pos] = prrs_pkg::MARK_SET;
                            ram_we = 1'b1;
                        end
                    end
                    else if (found_mark == prrs_pkg::MARK_WAIT)
                    begin
                        em_oc  = prrs_pkg::OC_BLOCKED;
                        em_lvl = f_lvl_reg;
                        em_pos = f_pos_reg;
                        go_on  = 1'b0;
                    end

                    if (go_on)
                    begin
                        em_lvl = tgt_lvl;
                        em_pos = tgt_pos;
                        if (token_reg != '0)
                        begin
                            token_next = token_reg - 1'b1;
                            em_oc      = prrs_pkg::OC_ACQUIRED;
                        end
                        else
                        begin
                            mark_next[tgt_lvl][tgt_pos] = prrs_pkg::MARK_WAIT;
                            if (waiters_reg != prrs_pkg::WAITER_MAX)
                                waiters_next = waiters_reg + 1'b1;
                            em_oc = prrs_pkg::OC_BLOCKED;
                        end
                    end
                end
            end

            ST_REL:
            begin
                if (rel_hit)
                begin
                    mark_next[rel_lvl_reg][rel_pos] = prrs_pkg::MARK_FREE;
                    if (int'(rel_pos) == SLOTS_PER_LEVEL - 1)
                        rr_ptr_next[rel_lvl_reg] = '0;
                    else
                        rr_ptr_next[rel_lvl_reg] = pos_t'(int'(rel_pos) + 1);
                    if (waiters_reg != '0)
                        waiters_next = waiters_reg - 1'b1;
                    f_lvl_next = rel_lvl_reg;
                    f_pos_next = rel_pos;
                    ram_raddr  = slot_addr(rel_lvl_reg, rel_pos);
                    state_next = ST_REL_OUT;
                end
                else if (rel_lvl_reg == '0)
                begin
                    // nobody waiting: add a saturating token
                    if (token_reg != '1)
                        token_next = token_reg + 1'b1;
                    em_oc      = prrs_pkg::OC_TOKEN;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rel_lvl_next = rel_lvl_reg - 1'b1;
                end
            end

            ST_REL_OUT:
            begin
                // token count unchanged: hand-over merges inc and dec
                em_oc      = prrs_pkg::OC_HANDED;
                em_lvl     = f_lvl_reg;
                em_pos     = f_pos_reg;
                em_woken   = ram_rdata;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (done_next)
        begin
            outcome_next     = em_oc;
            slot_level_next  = prrs_pkg::lvl_port_t'(em_lvl);
            slot_index_next  = prrs_pkg::pos_port_t'(em_pos);
            woken_id_next    = prrs_pkg::id_port_t'(em_woken);
            tokens_left_next = prrs_pkg::tok_port_t'(token_next);
            waiters_now_next = waiters_next;
        end

        if (cfg_we)
            token_next = tok_t'(cfg_wdata);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            token_reg   <= '0;
            waiters_reg <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                rr_ptr_reg[l] <= '0;
                for (int j = 0; j < SLOTS_PER_LEVEL; j++)
                    mark_reg[l][j] <= prrs_pkg::MARK_FREE;
            end
        end
        else
        begin
            state_reg   <= state_next;
            token_reg   <= token_next;
            waiters_reg <= waiters_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
            rr_ptr_reg  <= rr_ptr_next;
            mark_reg    <= mark_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        id_reg          <= id_next;
        lvl_reg         <= lvl_next;
        scan_lvl_reg    <= scan_lvl_next;
        scan_pos_reg    <= scan_pos_next;
        cmp_lvl_reg     <= cmp_lvl_next;
        cmp_pos_reg     <= cmp_pos_next;
        cmp_last_reg    <= cmp_last_next;
        found_reg       <= found_next;
        f_lvl_reg       <= f_lvl_next;
        f_pos_reg       <= f_pos_next;
        rel_lvl_reg     <= rel_lvl_next;
        outcome_reg     <= outcome_next;
        slot_level_reg  <= slot_level_next;
        slot_index_reg  <= slot_index_next;
        woken_id_reg    <= woken_id_next;
        tokens_left_reg <= tokens_left_next;
        waiters_now_reg <= waiters_now_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign outcome     = outcome_reg;
    assign slot_level  = slot_level_reg;
    assign slot_index  = slot_index_reg;
    assign woken_id    = woken_id_reg;
    assign tokens_left = tokens_left_reg;
    assign waiters_now = waiters_now_reg;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the priority round-robin counting semaphore.
`timescale 1ns / 1ps

import prrs_pkg::*;

// One expected or observed result word.
typedef struct packed {
    outcome_t  outcome;
    lvl_port_t lvl;
    pos_port_t pos;
    id_port_t  woken;
    tok_port_t tokens;
    waiter_t   waiters;
} slot_answer_t;

// Mirror of the slot table and counters, plus the queue of pending answers.
class token_ledger;
    localparam int LEVELS = 4;
    localparam int DEPTH  = 8;
    localparam int SLOTS  = LEVELS * DEPTH;
    localparam tok_port_t TOKEN_TOP = 16'hFFFF;

    mark_t        mark [SLOTS];
    id_port_t     owner [SLOTS];
    pos_port_t    rr_pos [LEVELS];
    tok_port_t    tokens;
    waiter_t      waiters;
    slot_answer_t expected_answers [$];
    int           mismatches;
    int           checked;
    int           outcome_seen [6];

    function new();
        foreach (mark[i]) mark[i] = MARK_FREE;
        foreach (rr_pos[i]) rr_pos[i] = '0;
        foreach (outcome_seen[i]) outcome_seen[i] = 0;
        tokens     = '0;
        waiters    = '0;
        mismatches = 0;
        checked    = 0;
    endfunction

    function int pending();
        return expected_answers.size();
    endfunction

    function void load(tok_port_t value);
        tokens = value;
    endfunction

    // first occupied slot owned by id, level 0 upward
    function int locate(id_port_t id);
        for (int s = 0; s < SLOTS; s++)
            if (mark[s] != MARK_FREE && owner[s] == id)
                return s;
        return -1;
    endfunction

    function int first_free(int lv);
        for (int j = 0; j < DEPTH; j++)
            if (mark[lv * DEPTH + j] == MARK_FREE)
                return lv * DEPTH + j;
        return -1;
    endfunction

    // Advance the mirror by one accepted word and queue its answer.
    function void note_word(action_t act, id_port_t id, lvl_port_t lvl_in);
        slot_answer_t ans;
        int           lv;
        int           hit;
        int           slot;
        int           k;
        bit           found;
        lv    = int'(lvl_in);
        if (lv >= LEVELS)
            lv = LEVELS - 1;
        ans   = '0;
        slot  = -1;
        found = 1'b0;
        hit   = locate(id);
        case (act)
            ACT_SET:
            begin
                if (hit >= 0 && hit / DEPTH == lv)
                begin
                    ans.outcome = OC_REGISTERED;
                    slot = hit;
                end
                else
                begin
                    slot = first_free(lv);
                    if (slot < 0)
                    begin
                        // target level full: old slot untouched
                        ans.outcome = OC_NO_SLOT;
                        ans.lvl     = lvl_port_t'(lv);
                    end
                    else
                    begin
                        mark[slot]  = (hit >= 0) ? mark[hit] : MARK_SET;
                        owner[slot] = id;
                        if (hit >= 0)
                            mark[hit] = MARK_FREE;
                        ans.outcome = OC_REGISTERED;
                    end
                end
            end
            ACT_ACQ:
            begin
                slot = hit;
                if (hit < 0)
                begin
                    slot = first_free(0);
                    if (slot < 0)
                        ans.outcome = OC_NO_SLOT;
                    else
                    begin
                        mark[slot]  = MARK_SET;
                        owner[slot] = id;
                    end
                end
                if (slot >= 0)
                begin
                    if (mark[slot] == MARK_WAIT)
                        ans.outcome = OC_BLOCKED;
                    else if (tokens != 0)
                    begin
                        tokens--;
                        ans.outcome = OC_ACQUIRED;
                    end
                    else
                    begin
                        mark[slot] = MARK_WAIT;
                        if (waiters != WAITER_MAX)
                            waiters++;
                        ans.outcome = OC_BLOCKED;
                    end
                end
            end
            ACT_REL:
            begin
                // highest level first, round robin inside the level
                for (int l = LEVELS - 1; l >= 0 && !found; l--)
                begin
                    for (int p = 0; p < DEPTH && !found; p++)
                    begin
                        k = l * DEPTH + (int'(rr_pos[l]) + p) % DEPTH;
                        if (mark[k] == MARK_WAIT)
                        begin
                            found     = 1'b1;
                            slot      = k;
                            rr_pos[l] = pos_port_t'((k % DEPTH + 1) % DEPTH);
                            ans.woken = owner[k];
                            mark[k]   = MARK_FREE;
                            if (waiters != 0)
                                waiters--;
                            ans.outcome = OC_HANDED;
                        end
                    end
                end
                if (!found)
                begin
                    if (tokens != TOKEN_TOP)
                        tokens++;
                    ans.outcome = OC_TOKEN;
                end
            end
            default:
                ans.outcome = OC_NO_SLOT;
        endcase
        if (slot >= 0)
        begin
            ans.lvl = lvl_port_t'(slot / DEPTH);
            ans.pos = pos_port_t'(slot % DEPTH);
        end
        ans.tokens  = tokens;
        ans.waiters = waiters;
        outcome_seen[ans.outcome]++;
        expected_answers.push_back(ans);
    endfunction

    task report(string what);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got %0h, expected %0h",
                             checked, name, got, want));
    endtask

    task check_result(slot_answer_t got);
        slot_answer_t want;
        if (expected_answers.size() == 0)
        begin
            report($sformatf("result with no word pending, outcome %0d", got.outcome));
            return;
        end
        want = expected_answers.pop_front();
        compare_field("outcome", 16'(got.outcome), 16'(want.outcome));
        compare_field("slot_level", 16'(got.lvl), 16'(want.lvl));
        compare_field("slot_index", 16'(got.pos), 16'(want.pos));
        compare_field("woken_id", got.woken, want.woken);
        compare_field("tokens_left", got.tokens, want.tokens);
        compare_field("waiters_now", 16'(got.waiters), 16'(want.waiters));
        checked++;
    endtask
endclass

module tb;

    // spare action code: the block answers "no free slot" and changes nothing
    localparam action_t ACT_UNUSED = 2'd3;
    // idle cycles with no word moving either way before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // covers the longest busy stretch, a full 32-slot walk of the owner RAM
    localparam int SETTLE = 40;
    localparam int POOL = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    action_t     action = ACT_SET;
    id_port_t    requester_id = '0;
    lvl_port_t   req_level = '0;
    logic        cfg_we = 1'b0;
    tok_port_t   cfg_wdata = '0;

    logic        busy;
    logic        done;
    outcome_t    outcome;
    lvl_port_t   slot_level;
    pos_port_t   slot_index;
    id_port_t    woken_id;
    tok_port_t   tokens_left;
    waiter_t     waiters_now;

    token_ledger  ledger;
    slot_answer_t observed;
    id_port_t     id_pool [POOL];
    int           words_sent = 0;
    int           stall_cycles = 0;

    priority_round_robin_semaphore dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .requester_id (requester_id),
        .req_level    (req_level),
        .done         (done),
        .outcome      (outcome),
        .slot_level   (slot_level),
        .slot_index   (slot_index),
        .woken_id     (woken_id),
        .tokens_left  (tokens_left),
        .waiters_now  (waiters_now),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Monitor. Everything is sampled right at the rising edge, before the
    // block's own updates land, so the values seen are those the edge takes.
    // A new word is noted before a result is checked: results always belong
    // to older words, so the order only matters for a same-cycle answer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                ledger.note_word(action, requester_id, req_level);
                words_sent++;
            end
            if (done)
            begin
                observed = '{outcome, slot_level, slot_index, woken_id,
                             tokens_left, waiters_now};
                ledger.check_result(observed);
            end
        end
    end

    // Watchdog: a long run of cycles where no word moves means a hang.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no word moved for %0d cycles, %0d pending",
                     $time, STALL_LIMIT, ledger.pending());
            $display("Verification failed");
            $finish;
        end
    end

    // Present one word and hold it until the block takes it. Called at a
    // rising edge; returns at the edge that accepted the word, with start
    // still high so a back-to-back word needs no drop.
    task send_word(action_t act, id_port_t id, lvl_port_t lvl);
        start        <= 1'b1;
        action       <= act;
        requester_id <= id;
        req_level    <= lvl;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Sender gap at random, about 35 times in a hundred, skipped when quiet.
    task maybe_idle(bit quiet);
        if (!quiet && $urandom_range(0, 99) < 35)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every pending answer to come back. It first
    // waits for the next edge, so that the calling edge's word is already noted.
    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    // Load the token counter with the block idle: drain, let any walk
    // finish, then pulse the write enable for one edge.
    task load_tokens(tok_port_t value);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ledger.load(value);
    endtask

    // Random words. Most ids come from a small pool so that lookups hit,
    // waiters pile up and get handed over; a few are fresh random ids.
    // Items in [quiet_lo, quiet_hi) go back to back; hold_at, when in
    // range, makes the sender wait for the block to empty.
    task run_random(int count, int quiet_lo, int quiet_hi, int hold_at);
        int      pick;
        action_t act;
        id_port_t id;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                act = ACT_SET;
            else if (pick < 62)
                act = ACT_ACQ;
            else if (pick < 97)
                act = ACT_REL;
            else
                act = ACT_UNUSED;
            if ($urandom_range(0, 99) < 88)
                id = id_pool[$urandom_range(0, POOL - 1)];
            else
                id = id_port_t'($urandom_range(0, 16'hFFFF));
            if (n == hold_at)
                drain();
            send_word(act, id, lvl_port_t'($urandom_range(0, 3)));
            maybe_idle(n >= quiet_lo && n < quiet_hi);
        end
    endtask

    initial
    begin
        ledger = new();
        // fixed ids first (directed part), the rest random
        id_pool[0] = 16'h5A5A;
        id_pool[1] = 16'hFFFF;
        id_pool[2] = 16'h0000;
        id_pool[3] = 16'h0300;
        for (int i = 0; i < 8; i++)
            id_pool[4 + i] = id_port_t'(16'h0100 + i);
        for (int i = 12; i < POOL; i++)
            id_pool[i] = id_port_t'($urandom_range(0, 16'hFFFF));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, counter starts empty ----
        load_tokens(16'd0);
        send_word(ACT_REL, 16'h1234, 2'd0);   // nobody waits: token added
        send_word(ACT_ACQ, 16'h5A5A, 2'd0);   // unknown: registers at 0, takes it
        send_word(ACT_ACQ, 16'h5A5A, 2'd0);   // counter empty: blocks
        maybe_idle(1'b0);
        send_word(ACT_ACQ, 16'h5A5A, 2'd0);   // already waiting: no change
        send_word(ACT_SET, 16'h5A5A, 2'd3);   // move keeps the waiting mark
        send_word(ACT_SET, 16'h5A5A, 2'd3);   // same level again
        send_word(ACT_ACQ, 16'hFFFF, 2'd1);   // all-ones id blocks at 0/0
        send_word(ACT_ACQ, 16'h0000, 2'd2);   // all-zeros id blocks at 0/1
        maybe_idle(1'b0);
        send_word(ACT_REL, 16'h0000, 2'd0);   // top level served first
        send_word(ACT_REL, 16'h0000, 2'd0);   // then round robin at level 0
        send_word(ACT_REL, 16'h0000, 2'd0);
        // fill level 0 with registered requesters
        for (int i = 0; i < 8; i++)
            send_word(ACT_SET, id_port_t'(16'h0100 + i), 2'd0);
        send_word(ACT_ACQ, 16'h01FF, 2'd0);   // unknown, level 0 full
        send_word(ACT_SET, 16'h0300, 2'd2);
        send_word(ACT_SET, 16'h0300, 2'd0);   // move into a full level refused
        send_word(ACT_UNUSED, 16'hFFFF, 2'd3);
        send_word(ACT_SET, 16'h0100, 2'd1);   // opens a slot at level 0 again

        // ---- counter at its top: saturation, then mostly acquires pass ----
        load_tokens(16'hFFFF);
        send_word(ACT_REL, 16'h0000, 2'd0);
        run_random(150, 0, 0, -1);

        // ---- empty counter: heavy blocking and handover ----
        load_tokens(16'd0);
        run_random(400, 100, 250, 300);

        // ---- single token ----
        load_tokens(16'd1);
        run_random(300, 0, 0, 150);

        load_tokens(16'd3);
        run_random(200, 0, 0, -1);

        load_tokens(tok_port_t'($urandom_range(0, 16'hFFFF)));
        run_random(80, 0, 0, -1);

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d words over token settings 0, 1, 3, a random one and the top,",
                 words_sent);
        $display("%0d answers checked: registered %0d, acquired %0d, blocked %0d,",
                 ledger.checked, ledger.outcome_seen[OC_REGISTERED],
                 ledger.outcome_seen[OC_ACQUIRED], ledger.outcome_seen[OC_BLOCKED]);
        $display("handed %0d, token %0d, no slot %0d",
                 ledger.outcome_seen[OC_HANDED], ledger.outcome_seen[OC_TOKEN],
                 ledger.outcome_seen[OC_NO_SLOT]);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
